>>> rtl/cba_pkg.sv
// Shared constants, types and word-mask helpers for the cluster bitmap allocator.
`timescale 1ns / 1ps

package cba_pkg;

  // Map geometry.
  localparam int NUM_CLUSTERS = 16384;
  localparam int FIRST_USABLE = 2;
  localparam int WORD_W       = 64;
  localparam int BIT_W        = $clog2(WORD_W);
  localparam int NUM_WORDS    = (NUM_CLUSTERS + WORD_W - 1) / WORD_W;
  localparam int ADDR_W       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int PTR_W        = ADDR_W + BIT_W;
  localparam int FIRST_WORD   = FIRST_USABLE / WORD_W;
  // The distinct words that a scan visits. The start word is visited twice.
  localparam int SCAN_WORDS   = NUM_WORDS - FIRST_WORD;
  localparam int VISIT_W      = $clog2(SCAN_WORDS + 2);

  // Field widths on the ports.
  localparam int CMD_W     = 2;
  localparam int NUMBER_W  = 16;
  localparam int CLUSTER_W = 14;
  localparam int STATUS_W  = 3;

  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [BIT_W-1:0]     bit_idx_t;
  typedef logic [PTR_W-1:0]     ptr_t;
  typedef logic [CMD_W-1:0]     cmd_t;
  typedef logic [NUMBER_W-1:0]  number_t;
  typedef logic [CLUSTER_W-1:0] cluster_t;
  typedef logic [STATUS_W-1:0]  status_t;

  // Command codes.
  localparam cmd_t CMD_ALLOC = 2'd0;
  localparam cmd_t CMD_FREE  = 2'd1;
  localparam cmd_t CMD_CLEAR = 2'd2;

  // Status codes.
  localparam status_t STAT_ALLOCATED = 3'd0;
  localparam status_t STAT_FREED     = 3'd1;
  localparam status_t STAT_IGNORED   = 3'd2;
  localparam status_t STAT_FULL      = 3'd3;
  localparam status_t STAT_CLEARED   = 3'd4;

  // Request from the controller to the map store.
  typedef struct packed {
    logic  rd_en;
    addr_t rd_addr;
    logic  wr_en;
    addr_t wr_addr;
    word_t wr_data;
    logic  clear;
  } map_req_t;

  // Finished result from the controller to the output stage.
  typedef struct packed {
    logic     valid;
    cluster_t cluster;
    status_t  status;
  } result_t;

  // Bits of a word that hold clusters an allocate may grant.
  function automatic word_t usable_mask(input addr_t a);
    word_t m;
    int    c;
    for (int i = 0; i < WORD_W; i++) begin
      c    = int'(a) * WORD_W + i;
      m[i] = (c >= FIRST_USABLE) && (c < NUM_CLUSTERS);
    end
    return m;
  endfunction

  // Contents of a word right after reset or a clear command.
  function automatic word_t reset_word(input addr_t a);
    word_t m;
    int    c;
    for (int i = 0; i < WORD_W; i++) begin
      c    = int'(a) * WORD_W + i;
      m[i] = (c < FIRST_USABLE);
    end
    return m;
  endfunction

endpackage

>>> rtl/cluster_bitmap_allocator_core.sv
// Top level of the next-fit cluster bitmap allocator with its output register.
`timescale 1ns / 1ps

// Channel  Signals                                        Direction
// -------  ---------------------------------------------  ---------
// in       in_valid, in_stall, command, cluster_number      into block
// out      out_valid, out_stall, allocated_cluster, status  out of block
//
// One word is taken at a time; in_stall is high from acceptance until the
// result has moved into the output register.
// Allocate: the scan examines the 64-bit map words in order. It reads the map
// memory one word per cycle with one read in flight. A hit in the start word
// ends the scan; a full map scans all 256 words and the start word again.
// Free: read, write back, hand-off; clear and ignored commands: hand-off only.
// Reset and clear take effect at once: per-word valid bits make every
// unwritten word read as empty, except clusters 0 and 1, which read as used.
// A held out_stall keeps the result in the output register; the next command
// is still accepted and runs, and waits for the register only at its end.

module cluster_bitmap_allocator_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                command,
  input  logic [15:0]               cluster_number,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [13:0]               allocated_cluster,
  output logic [2:0]                status
);

  cba_pkg::map_req_t map_req;
  cba_pkg::word_t    map_rd_data;
  cba_pkg::result_t  result;
  logic              out_free;
  logic              result_take;

  // The output register can load when it is empty or its word leaves this cycle.
  assign out_free    = !out_valid || !out_stall;
  assign result_take = result.valid && out_free;

  cba_map u_map (
    .clk    (clk),
    .rst    (rst),
    .req    (map_req),
    .rd_data(map_rd_data)
  );

  cba_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .command       (command),
    .cluster_number(cluster_number),
    .map_req       (map_req),
    .map_rd_data   (map_rd_data),
    .result        (result),
    .result_take   (result_take)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (result_take) begin
      allocated_cluster <= result.cluster;
      status            <= result.status;
    end
  end

endmodule

>>> rtl/cba_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module cba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/cba_map.sv
// Usage map store: word RAM plus per-word valid bits that stand for the cleared state.
`timescale 1ns / 1ps

module cba_map (
  input  logic              clk,
  input  logic              rst,
  input  cba_pkg::map_req_t req,
  output cba_pkg::word_t    rd_data
);

  logic [cba_pkg::NUM_WORDS-1:0] valid;
  logic                          rd_valid;
  cba_pkg::addr_t                rd_addr;
  cba_pkg::word_t                ram_q;

  cba_ram #(
    .WIDTH(cba_pkg::WORD_W),
    .DEPTH(cba_pkg::NUM_WORDS)
  ) u_ram (
    .clk  (clk),
    .we   (req.wr_en),
    .waddr(req.wr_addr),
    .wdata(req.wr_data),
    .re   (req.rd_en),
    .raddr(req.rd_addr),
    .rdata(ram_q)
  );

  // A word never written since the last clear reads as its reset contents.
  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      valid <= '0;
    end else if (req.wr_en) begin
      valid[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_valid <= valid[req.rd_addr];
      rd_addr  <= req.rd_addr;
    end
  end

  assign rd_data = rd_valid ? ram_q : cba_pkg::reset_word(rd_addr);

endmodule

>>> rtl/cba_ctrl.sv
// Command sequencer: next-fit word scan, free read-modify-write, clear and pointer.
`timescale 1ns / 1ps

module cba_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  cba_pkg::cmd_t       command,
  input  cba_pkg::number_t    cluster_number,
  output cba_pkg::map_req_t   map_req,
  input  cba_pkg::word_t      map_rd_data,
  output cba_pkg::result_t    result,
  input  logic                result_take
);

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_FREE    = 4'b0010,
    S_SCAN    = 4'b0100,
    S_DELIVER = 4'b1000
  } state_t;

  localparam int                   PTR_W_EXT = cba_pkg::PTR_W + 1;
  localparam logic [PTR_W_EXT-1:0] TOTAL_EXT = PTR_W_EXT'(cba_pkg::NUM_CLUSTERS);
  localparam logic [PTR_W_EXT-1:0] FIRST_EXT = PTR_W_EXT'(cba_pkg::FIRST_USABLE);
  localparam logic [cba_pkg::NUMBER_W:0] NUM_LIMIT =
    (cba_pkg::NUMBER_W + 1)'(cba_pkg::NUM_CLUSTERS);

  state_t              state, state_next;
  cba_pkg::ptr_t       ptr, ptr_next;
  cba_pkg::addr_t      eval_addr, eval_addr_next;
  logic [cba_pkg::VISIT_W-1:0] visit, visit_next;
  cba_pkg::bit_idx_t   pos_bit, pos_bit_next;
  cba_pkg::addr_t      free_addr, free_addr_next;
  cba_pkg::bit_idx_t   free_bit, free_bit_next;
  cba_pkg::cluster_t   res_cluster, res_cluster_next;
  cba_pkg::status_t    res_status, res_status_next;

  logic                accept;
  cba_pkg::ptr_t       start_pos;
  cba_pkg::addr_t      start_word;
  cba_pkg::addr_t      scan_next_addr;
  cba_pkg::word_t      pos_lo_mask;
  cba_pkg::word_t      visit_mask;
  cba_pkg::word_t      free_bits;
  logic                found;
  cba_pkg::bit_idx_t   found_bit;
  cba_pkg::ptr_t       found_cluster;
  logic [PTR_W_EXT-1:0] after_found;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  assign result.valid   = (state == S_DELIVER);
  assign result.cluster = res_cluster;
  assign result.status  = res_status;

  // A pointer outside the usable range restarts the scan at the first usable cluster.
  always_comb begin
    if (({1'b0, ptr} < FIRST_EXT) || ({1'b0, ptr} >= TOTAL_EXT)) begin
      start_pos = cba_pkg::ptr_t'(cba_pkg::FIRST_USABLE);
    end else begin
      start_pos = ptr;
    end
    start_word = start_pos[cba_pkg::PTR_W-1:cba_pkg::BIT_W];
  end

  // Word order of the scan: up to the last word, then back to the first usable word.
  assign scan_next_addr = (eval_addr == cba_pkg::addr_t'(cba_pkg::NUM_WORDS - 1)) ?
                          cba_pkg::addr_t'(cba_pkg::FIRST_WORD) :
                          eval_addr + cba_pkg::addr_t'(1);

  // The start word is seen twice: first its bits at and above the pointer, at the
  // end of the pass the bits below it.
  assign pos_lo_mask = (cba_pkg::word_t'(1) << pos_bit) - cba_pkg::word_t'(1);

  always_comb begin
    if (visit == '0) begin
      visit_mask = ~pos_lo_mask;
    end else if (visit == cba_pkg::VISIT_W'(cba_pkg::SCAN_WORDS)) begin
      visit_mask = pos_lo_mask;
    end else begin
      visit_mask = '1;
    end
    free_bits = ~map_rd_data & visit_mask & cba_pkg::usable_mask(eval_addr);
  end

  // Lowest clear bit of the word.
  always_comb begin
    found     = |free_bits;
    found_bit = '0;
    for (int i = cba_pkg::WORD_W - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        found_bit = cba_pkg::bit_idx_t'(i);
      end
    end
    found_cluster = {eval_addr, found_bit};
    after_found   = {1'b0, found_cluster} + PTR_W_EXT'(1);
  end

  always_comb begin
    state_next       = state;
    ptr_next         = ptr;
    eval_addr_next   = eval_addr;
    visit_next       = visit;
    pos_bit_next     = pos_bit;
    free_addr_next   = free_addr;
    free_bit_next    = free_bit;
    res_cluster_next = res_cluster;
    res_status_next  = res_status;
    map_req          = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          res_cluster_next = '0;
          unique case (command)
            cba_pkg::CMD_ALLOC: begin
              map_req.rd_en  = 1'b1;
              map_req.rd_addr = start_word;
              eval_addr_next = start_word;
              pos_bit_next   = start_pos[cba_pkg::BIT_W-1:0];
              visit_next     = '0;
              state_next     = S_SCAN;
            end
            cba_pkg::CMD_FREE: begin
              if ({1'b0, cluster_number} < NUM_LIMIT) begin
                map_req.rd_en   = 1'b1;
                map_req.rd_addr =
                  cluster_number[cba_pkg::PTR_W-1:cba_pkg::BIT_W];
                free_addr_next  =
                  cluster_number[cba_pkg::PTR_W-1:cba_pkg::BIT_W];
                free_bit_next   = cluster_number[cba_pkg::BIT_W-1:0];
                state_next      = S_FREE;
              end else begin
                res_status_next = cba_pkg::STAT_IGNORED;
                state_next      = S_DELIVER;
              end
            end
            cba_pkg::CMD_CLEAR: begin
              map_req.clear   = 1'b1;
              ptr_next        = cba_pkg::ptr_t'(cba_pkg::FIRST_USABLE);
              res_status_next = cba_pkg::STAT_CLEARED;
              state_next      = S_DELIVER;
            end
            default: begin
              res_status_next = cba_pkg::STAT_IGNORED;
              state_next      = S_DELIVER;
            end
          endcase
        end
      end

      S_FREE: begin
        map_req.wr_en   = 1'b1;
        map_req.wr_addr = free_addr;
        map_req.wr_data = map_rd_data & ~(cba_pkg::word_t'(1) << free_bit);
        res_status_next = cba_pkg::STAT_FREED;
        state_next      = S_DELIVER;
      end

      S_SCAN: begin
        // Keep one read in flight ahead of the word being examined.
        map_req.rd_en   = 1'b1;
        map_req.rd_addr = scan_next_addr;
        if (found) begin
          map_req.wr_en    = 1'b1;
          map_req.wr_addr  = eval_addr;
          map_req.wr_data  = map_rd_data | (cba_pkg::word_t'(1) << found_bit);
          res_cluster_next = cba_pkg::cluster_t'(found_cluster);
          res_status_next  = cba_pkg::STAT_ALLOCATED;
          ptr_next         = (after_found >= TOTAL_EXT) ?
                             cba_pkg::ptr_t'(cba_pkg::FIRST_USABLE) :
                             after_found[cba_pkg::PTR_W-1:0];
          state_next       = S_DELIVER;
        end else if (visit == cba_pkg::VISIT_W'(cba_pkg::SCAN_WORDS)) begin
          res_cluster_next = '0;
          res_status_next  = cba_pkg::STAT_FULL;
          state_next       = S_DELIVER;
        end else begin
          eval_addr_next = scan_next_addr;
          visit_next     = visit + cba_pkg::VISIT_W'(1);
        end
      end

      S_DELIVER: begin
        if (result_take) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ptr   <= cba_pkg::ptr_t'(cba_pkg::FIRST_USABLE);
    end else begin
      state <= state_next;
      ptr   <= ptr_next;
    end
  end

  always_ff @(posedge clk) begin
    eval_addr   <= eval_addr_next;
    visit       <= visit_next;
    pos_bit     <= pos_bit_next;
    free_addr   <= free_addr_next;
    free_bit    <= free_bit_next;
    res_cluster <= res_cluster_next;
    res_status  <= res_status_next;
  end

endmodule
